/* rtl/sawbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_pkg
// Shared sizes, codes and the command type of the write-back cache.
// ----------------------------------------------------------------------------
package sawbc_pkg;

  localparam int unsigned LINE_BITS = 6;
  localparam int unsigned SET_BITS  = 12;
  localparam int unsigned WAY_BITS  = 4;
  localparam int unsigned ADDR_BITS = 27;

  localparam int unsigned TAG_BITS  = ADDR_BITS - LINE_BITS - SET_BITS;
  localparam int unsigned WAYS      = 1 << WAY_BITS;
  localparam int unsigned SETS      = 1 << SET_BITS;
  localparam int unsigned WORD_BITS = LINE_BITS - 2;
  localparam int unsigned IDX_BITS  = SET_BITS + WAY_BITS;
  localparam int unsigned LANE_DEPTH = 1 << (IDX_BITS + WORD_BITS);
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned QDEPTH    = 4;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // input operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_RDATA   = 3'd0;
  localparam logic [2:0] KIND_WRDONE  = 3'd1;
  localparam logic [2:0] KIND_MEMWR   = 3'd2;
  localparam logic [2:0] KIND_FILLREQ = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // commands from front to back
  localparam logic [2:0] CMD_ERR       = 3'd0;
  localparam logic [2:0] CMD_WMISS     = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ      = 3'd3;
  localparam logic [2:0] CMD_MISS      = 3'd4;
  localparam logic [2:0] CMD_FILL_WORD = 3'd5;
  localparam logic [2:0] CMD_FILL_LAST = 3'd6;

  typedef struct packed {
    logic [2:0]           code;
    logic [IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0] addr;
    logic [2:0]           len;
    logic [31:0]          data;
    logic [LINE_BITS-1:0] woff;
    logic                 wb;
    logic [TAG_BITS-1:0]  wb_tag;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/sawbc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_if
// Valid/ready channels for access items and for result items.
// ----------------------------------------------------------------------------
interface sawbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [sawbc_pkg::ADDR_BITS-1:0] address;
  logic [2:0]  length;
  logic [31:0] write_data;
  logic [31:0] fill_word;
  modport source (output valid, operation, address, length, write_data, fill_word,
                  input ready);
  modport sink (input valid, operation, address, length, write_data, fill_word,
                output ready);
endinterface

interface sawbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] read_data;
  logic [sawbc_pkg::ADDR_BITS-1:0] memory_address;
  logic [31:0] memory_data;
  logic [2:0]  memory_length;
  logic        last;
  modport source (output valid, kind, read_data, memory_address, memory_data,
                  memory_length, last, input ready);
  modport sink (input valid, kind, read_data, memory_address, memory_data,
                memory_length, last, output ready);
endinterface
`default_nettype wire

/* rtl/sawbc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sawbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

/* rtl/sawbc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_front
// Accepts items, looks up tags and valid/dirty marks, picks victims, keeps the
// pending fill state and issues one command per item to the back end.
// ----------------------------------------------------------------------------
module sawbc_front (
  input  wire logic clk,
  input  wire logic rst_n,
  sawbc_in_if.sink  in_ch,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [sawbc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready,
  input  wire logic        q_full,
  output      logic        q_push,
  output sawbc_pkg::cmd_t  q_cmd
);
  localparam int unsigned LB = sawbc_pkg::LINE_BITS;
  localparam int unsigned SB = sawbc_pkg::SET_BITS;
  localparam int unsigned WB = sawbc_pkg::WAY_BITS;
  localparam int unsigned AB = sawbc_pkg::ADDR_BITS;
  localparam int unsigned TB = sawbc_pkg::TAG_BITS;
  localparam int unsigned NW = sawbc_pkg::WAYS;
  localparam int unsigned WDB = sawbc_pkg::WORD_BITS;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_DECIDE = 1'b1;

  logic          state_r;
  logic          clr_r;
  logic [SB-1:0] clr_cnt_r;

  logic [1:0]    op_r;
  logic [AB-1:0] addr_r;
  logic [2:0]    len_r;
  logic [31:0]   wd_r;
  logic [31:0]   fw_r;

  logic [15:0]   seed_r;
  logic [15:0]   lfsr_r, lfsr_nxt, lfsr_step;
  logic          fp_r, fp_nxt;
  logic [AB-1:0] pend_addr_r, pend_addr_nxt;
  logic [2:0]    pend_len_r, pend_len_nxt;
  logic [WB-1:0] pend_way_r, pend_way_nxt;
  logic [WDB-1:0] fill_cnt_r, fill_cnt_nxt;

  logic          accept;
  logic          cfg_we;
  logic [SB-1:0] rd_set;
  logic [SB-1:0] set;
  logic [SB-1:0] pset;
  logic [TB-1:0] tag;
  logic [LB-1:0] off;
  logic          bad;

  logic [2*NW-1:0] row_rd, row_nxt;
  logic          row_we;
  logic [SB-1:0] row_waddr;
  logic [2*NW-1:0] row_wdata;
  logic [TB-1:0] tag_rd [NW];
  logic [NW-1:0] tag_we;

  logic          hit;
  logic [WB-1:0] hit_way;
  logic          inv_found;
  logic [WB-1:0] inv_way;
  logic [WB-1:0] victim;
  sawbc_pkg::cmd_t cmd;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !clr_r;
  assign q_push   = (state_r == S_DECIDE) && !q_full;
  assign q_cmd    = cmd;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, seed_r};

  // hold the lookup set while the command waits for queue space
  assign rd_set = (state_r == S_DECIDE) ?
                    ((op_r == sawbc_pkg::OP_FILL) ? pset : set) :
                  (in_ch.operation == sawbc_pkg::OP_FILL) ? pend_addr_r[LB +: SB]
                                                          : in_ch.address[LB +: SB];
  assign set  = addr_r[LB +: SB];
  assign pset = pend_addr_r[LB +: SB];
  assign tag  = addr_r[AB-1 -: TB];
  assign off  = addr_r[LB-1:0];
  assign bad  = fp_r || (len_r == 3'd0) || (len_r > 3'd4) ||
                (({1'b0, off} + (LB+1)'(len_r)) > (LB+1)'(1 << LB));

  assign lfsr_step = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? sawbc_pkg::LFSR_TAPS : 16'd0);

  // valid marks in the low half, dirty marks in the high half
  assign row_we    = clr_r || q_push;
  assign row_waddr = clr_r ? clr_cnt_r : ((op_r == sawbc_pkg::OP_FILL) ? pset : set);
  assign row_wdata = clr_r ? '0 : row_nxt;

  sawbc_ram #(.WIDTH(2*NW), .DEPTH(sawbc_pkg::SETS)) u_marks (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(rd_set), .rdata(row_rd)
  );

  for (genvar w = 0; w < NW; w++) begin : g_tag
    sawbc_ram #(.WIDTH(TB), .DEPTH(sawbc_pkg::SETS)) u_tag (
      .clk(clk), .we(tag_we[w] && q_push), .waddr(set), .wdata(tag),
      .raddr(rd_set), .rdata(tag_rd[w])
    );
  end

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    inv_found = 1'b0;
    inv_way = '0;
    // descending scan so the lowest way wins
    for (int w = NW - 1; w >= 0; w--) begin
      if (row_rd[w] && tag_rd[w] == tag) begin
        hit = 1'b1;
        hit_way = WB'(w);
      end
      if (!row_rd[w]) begin
        inv_found = 1'b1;
        inv_way = WB'(w);
      end
    end
    victim = inv_found ? inv_way : lfsr_step[WB-1:0];
  end

  always_comb begin
    cmd = '0;
    row_nxt = row_rd;
    tag_we = '0;
    lfsr_nxt = lfsr_r;
    fp_nxt = fp_r;
    pend_addr_nxt = pend_addr_r;
    pend_len_nxt = pend_len_r;
    pend_way_nxt = pend_way_r;
    fill_cnt_nxt = fill_cnt_r;
    cmd.addr = addr_r;
    cmd.len  = len_r;
    cmd.woff = off;
    if (op_r == sawbc_pkg::OP_FILL) begin
      if (!fp_r) begin
        cmd.code = sawbc_pkg::CMD_ERR;
      end else begin
        cmd.idx  = {pset, pend_way_r};
        cmd.addr = pend_addr_r;
        cmd.len  = pend_len_r;
        cmd.data = fw_r;
        cmd.woff = {fill_cnt_r, 2'b00};
        if (fill_cnt_r == '1) begin
          cmd.code = sawbc_pkg::CMD_FILL_LAST;
          row_nxt[{1'b0, pend_way_r}] = 1'b1;
          row_nxt[{1'b1, pend_way_r}] = 1'b0;
          fp_nxt = 1'b0;
          fill_cnt_nxt = '0;
        end else begin
          cmd.code = sawbc_pkg::CMD_FILL_WORD;
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
      end
    end else if ((op_r != sawbc_pkg::OP_READ && op_r != sawbc_pkg::OP_WRITE) || bad) begin
      cmd.code = sawbc_pkg::CMD_ERR;
    end else if (op_r == sawbc_pkg::OP_WRITE) begin
      cmd.data = wd_r;
      if (hit) begin
        cmd.code = sawbc_pkg::CMD_WRITE;
        cmd.idx  = {set, hit_way};
        row_nxt[{1'b1, hit_way}] = 1'b1;
      end else begin
        cmd.code = sawbc_pkg::CMD_WMISS;
      end
    end else if (hit) begin
      cmd.code = sawbc_pkg::CMD_READ;
      cmd.idx  = {set, hit_way};
    end else begin
      cmd.code   = sawbc_pkg::CMD_MISS;
      cmd.idx    = {set, victim};
      cmd.wb     = row_rd[{1'b0, victim}] && row_rd[{1'b1, victim}];
      cmd.wb_tag = tag_rd[victim];
      if (!inv_found) begin
        lfsr_nxt = lfsr_step;
      end
      row_nxt[{1'b0, victim}] = 1'b0;
      row_nxt[{1'b1, victim}] = 1'b0;
      tag_we[victim] = 1'b1;
      fp_nxt = 1'b1;
      pend_addr_nxt = addr_r;
      pend_len_nxt = len_r;
      pend_way_nxt = victim;
      fill_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
      seed_r <= 16'd1;
      lfsr_r <= 16'd1;
      fp_r <= 1'b0;
      pend_addr_r <= '0;
      pend_len_r <= '0;
      pend_way_r <= '0;
      fill_cnt_r <= '0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          clr_r <= 1'b0;
        end
      end
      if (state_r == S_IDLE) begin
        if (accept) begin
          state_r <= S_DECIDE;
        end
      end else if (q_push) begin
        state_r <= S_IDLE;
        fp_r <= fp_nxt;
        pend_addr_r <= pend_addr_nxt;
        pend_len_r <= pend_len_nxt;
        pend_way_r <= pend_way_nxt;
        fill_cnt_r <= fill_cnt_nxt;
      end
      if (cfg_we) begin
        seed_r <= cfg_pwdata[15:0];
        lfsr_r <= (cfg_pwdata[15:0] == 16'd0) ? 16'd1 : cfg_pwdata[15:0];
      end else if (q_push) begin
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.operation;
      addr_r <= in_ch.address;
      len_r  <= in_ch.length;
      wd_r   <= in_ch.write_data;
      fw_r   <= in_ch.fill_word;
    end
  end
endmodule
`default_nettype wire

/* rtl/sawbc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_queue
// Short command FIFO between the lookup front end and the data back end.
// ----------------------------------------------------------------------------
module sawbc_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  sawbc_pkg::cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output sawbc_pkg::cmd_t head,
  output      logic empty
);
  localparam int unsigned PB = $clog2(sawbc_pkg::QDEPTH);

  sawbc_pkg::cmd_t ent_r [sawbc_pkg::QDEPTH];
  logic [PB-1:0] wr_ptr_r;
  logic [PB-1:0] rd_ptr_r;
  logic [PB:0]   cnt_r;

  assign full  = (cnt_r == (PB+1)'(sawbc_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

/* rtl/sawbc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_back
// Executes commands on the line data store (four byte lanes) and drives the
// registered result channel: reads, writes, fills and victim writebacks.
// ----------------------------------------------------------------------------
module sawbc_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  sawbc_pkg::cmd_t head,
  input  wire logic empty,
  output      logic pop,
  sawbc_out_if.source out_ch
);
  localparam int unsigned LB  = sawbc_pkg::LINE_BITS;
  localparam int unsigned AB  = sawbc_pkg::ADDR_BITS;
  localparam int unsigned WDB = sawbc_pkg::WORD_BITS;
  localparam int unsigned LAB = sawbc_pkg::IDX_BITS + WDB;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_EXEC  = 3'd1;
  localparam logic [2:0] B_RDREQ = 3'd2;
  localparam logic [2:0] B_RDOUT = 3'd3;
  localparam logic [2:0] B_WBREQ = 3'd4;
  localparam logic [2:0] B_WBOUT = 3'd5;
  localparam logic [2:0] B_FREQ  = 3'd6;

  logic [2:0]      state_r, state_nxt;
  sawbc_pkg::cmd_t cur_r;
  logic [WDB-1:0]  wb_cnt_r, wb_cnt_nxt;

  logic            out_valid_r;
  logic [2:0]      kind_r;
  logic [31:0]     rdata_r;
  logic [AB-1:0]   maddr_r;
  logic [31:0]     mdata_r;
  logic [2:0]      mlen_r;
  logic            last_r;

  logic            slot_free;
  logic            load;
  logic [2:0]      ld_kind;
  logic [31:0]     ld_rdata;
  logic [AB-1:0]   ld_maddr;
  logic [31:0]     ld_mdata;
  logic [2:0]      ld_mlen;
  logic            ld_last;

  logic [LB-1:0]   acc_off;
  logic [2:0]      acc_len;
  logic            do_write;
  logic [1:0]      rel [4];
  logic [LB:0]     wpos [4];
  logic [LAB-1:0]  lane_addr [4];
  logic            lane_en [4];
  logic [7:0]      lane_wd [4];
  logic [7:0]      lane_rd [4];
  logic [1:0]      lane_sel [4];
  logic [31:0]     rd_word;
  logic [31:0]     wmask;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop = (state_r == B_IDLE) && !empty;

  always_comb begin
    unique case (state_r)
      B_EXEC: begin
        acc_off = cur_r.woff;
        acc_len = (cur_r.code == sawbc_pkg::CMD_FILL_WORD ||
                   cur_r.code == sawbc_pkg::CMD_FILL_LAST) ? 3'd4 : cur_r.len;
      end
      B_WBREQ, B_WBOUT: begin
        acc_off = {wb_cnt_r, 2'b00};
        acc_len = 3'd4;
      end
      default: begin
        acc_off = cur_r.addr[LB-1:0];
        acc_len = cur_r.len;
      end
    endcase
  end

  assign do_write = (state_r == B_EXEC) &&
                    ((cur_r.code == sawbc_pkg::CMD_WRITE && slot_free) ||
                     cur_r.code == sawbc_pkg::CMD_FILL_WORD ||
                     cur_r.code == sawbc_pkg::CMD_FILL_LAST);

  // route byte k of the access to lane (off + k) mod 4
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rel[l]       = 2'(l) - acc_off[1:0];
      wpos[l]      = {1'b0, acc_off} + (LB+1)'(rel[l]);
      lane_addr[l] = {cur_r.idx, wpos[l][LB-1:2]};
      lane_en[l]   = ({1'b0, rel[l]} < acc_len);
      lane_wd[l]   = cur_r.data[8*rel[l] +: 8];
    end
    for (int k = 0; k < 4; k++) begin
      lane_sel[k] = acc_off[1:0] + 2'(k);
      rd_word[8*k +: 8] = (3'(k) < acc_len) ? lane_rd[lane_sel[k]] : 8'd0;
      wmask[8*k +: 8]   = (3'(k) < acc_len) ? 8'hFF : 8'd0;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    sawbc_ram #(.WIDTH(8), .DEPTH(sawbc_pkg::LANE_DEPTH)) u_lane (
      .clk(clk), .we(do_write && lane_en[l]), .waddr(lane_addr[l]),
      .wdata(lane_wd[l]), .raddr(lane_addr[l]), .rdata(lane_rd[l])
    );
  end

  always_comb begin
    state_nxt = state_r;
    wb_cnt_nxt = wb_cnt_r;
    load = 1'b0;
    ld_kind = sawbc_pkg::KIND_ERROR;
    ld_rdata = '0;
    ld_maddr = '0;
    ld_mdata = '0;
    ld_mlen = '0;
    ld_last = 1'b1;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        case (cur_r.code)
          sawbc_pkg::CMD_WMISS: begin
            if (slot_free) begin
              load = 1'b1;
              ld_kind = sawbc_pkg::KIND_MEMWR;
              ld_maddr = cur_r.addr;
              ld_mdata = cur_r.data & wmask;
              ld_mlen = cur_r.len;
              state_nxt = B_IDLE;
            end
          end
          sawbc_pkg::CMD_WRITE: begin
            if (slot_free) begin
              load = 1'b1;
              ld_kind = sawbc_pkg::KIND_WRDONE;
              state_nxt = B_IDLE;
            end
          end
          sawbc_pkg::CMD_FILL_WORD: state_nxt = B_IDLE;
          sawbc_pkg::CMD_FILL_LAST, sawbc_pkg::CMD_READ: state_nxt = B_RDREQ;
          sawbc_pkg::CMD_MISS: begin
            wb_cnt_nxt = '0;
            state_nxt = cur_r.wb ? B_WBREQ : B_FREQ;
          end
          default: begin
            if (slot_free) begin
              load = 1'b1;
              state_nxt = B_IDLE;
            end
          end
        endcase
      end
      B_RDREQ: state_nxt = B_RDOUT;
      B_RDOUT: begin
        if (slot_free) begin
          load = 1'b1;
          ld_kind = sawbc_pkg::KIND_RDATA;
          ld_rdata = rd_word;
          state_nxt = B_IDLE;
        end
      end
      B_WBREQ: state_nxt = B_WBOUT;
      B_WBOUT: begin
        if (slot_free) begin
          load = 1'b1;
          ld_kind = sawbc_pkg::KIND_MEMWR;
          ld_maddr = {cur_r.wb_tag, cur_r.addr[LB +: sawbc_pkg::SET_BITS], wb_cnt_r, 2'b00};
          ld_mdata = rd_word;
          ld_mlen = 3'd4;
          ld_last = 1'b0;
          if (wb_cnt_r == '1) begin
            state_nxt = B_FREQ;
          end else begin
            wb_cnt_nxt = wb_cnt_r + 1'b1;
            state_nxt = B_WBREQ;
          end
        end
      end
      B_FREQ: begin
        if (slot_free) begin
          load = 1'b1;
          ld_kind = sawbc_pkg::KIND_FILLREQ;
          ld_maddr = {cur_r.addr[AB-1:LB], {LB{1'b0}}};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
      wb_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      wb_cnt_r <= wb_cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (load) begin
      kind_r  <= ld_kind;
      rdata_r <= ld_rdata;
      maddr_r <= ld_maddr;
      mdata_r <= ld_mdata;
      mlen_r  <= ld_mlen;
      last_r  <= ld_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.read_data      = rdata_r;
  assign out_ch.memory_address = maddr_r;
  assign out_ch.memory_data    = mdata_r;
  assign out_ch.memory_length  = mlen_r;
  assign out_ch.last           = last_r;
endmodule
`default_nettype wire

/* rtl/set_associative_write_back_cache.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_associative_write_back_cache
// 16-way, 4096-set write-back cache with 64-byte lines and random replacement.
// ----------------------------------------------------------------------------
// Items enter on in_ch (read, write or fill word) and results leave on out_ch
// as valid/ready transfers; last marks the final result of an item. The APB
// port holds random_seed at 0-3; writing it reloads the replacement LFSR.
// The front end reads the tag/mark RAMs for an item, then decides and queues a
// command, taking no new item until it is queued; the back end runs commands
// on the line store. A write, write miss or error result is loaded from the
// back end's execute state; a read hit first reads the lane RAMs. A dirty read
// miss emits 16 writeback words (a lane RAM read per word) and then the fill
// request. The read completes after the 16th fill word.
// After reset a clearing pass zeroes the valid/dirty marks of all 4096 sets,
// one set per cycle; in_ch.ready stays low until it ends.
// A stalled out_ch holds the result register; the 4-entry command queue lets
// the front keep accepting until it fills.
// ----------------------------------------------------------------------------
module set_associative_write_back_cache (
  input  wire logic clk,
  input  wire logic rst_n,
  sawbc_in_if.sink    in_ch,
  sawbc_out_if.source out_ch,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [sawbc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  sawbc_pkg::cmd_t q_in;
  sawbc_pkg::cmd_t q_head;

  sawbc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_in)
  );

  sawbc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_in), .full(q_full),
    .pop(q_pop), .head(q_head), .empty(q_empty)
  );

  sawbc_back u_back (
    .clk(clk), .rst_n(rst_n), .head(q_head), .empty(q_empty), .pop(q_pop),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire

/* bench/sawbc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_checker
// Watches the access, result and register ports of the write-back cache,
// predicts every result from its own copy of the cache state, and counts
// results that are wrong, unexpected or still owed.
// ----------------------------------------------------------------------------
module sawbc_checker
  import sawbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sawbc_in_if         in_mon,
  sawbc_out_if        out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          failures,
  output int          outstanding
);

  localparam int unsigned LINE_SIZE = 1 << LINE_BITS;
  localparam int unsigned LINE_WORDS = LINE_SIZE / 4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RANDOM_SEED = '0;

  typedef struct packed {
    logic [2:0]           kind;
    logic [31:0]          read_data;
    logic [ADDR_BITS-1:0] memory_address;
    logic [31:0]          memory_data;
    logic [2:0]           memory_length;
    logic                 last;
  } cache_result_t;

  cache_result_t        expected_results[$];

  logic [TAG_BITS-1:0]  tags[int];
  bit                   valid_mark[int];
  bit                   dirty_mark[int];
  logic [7:0]           line_store[int];
  logic [15:0]          lfsr;
  bit                   fill_busy;
  logic [ADDR_BITS-1:0] fill_addr;
  logic [2:0]           fill_len;
  int                   fill_way;
  int                   fill_words;

  function automatic logic [7:0] byte_at(int key);
    return line_store.exists(key) ? line_store[key] : 8'h00;
  endfunction

  function automatic logic [31:0] bytes_at(int key, int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = byte_at(key + i);
    return v;
  endfunction

  function automatic void push_result(logic [2:0] kind, logic [31:0] rd,
                                      logic [ADDR_BITS-1:0] ma, logic [31:0] md,
                                      logic [2:0] ml, logic last);
    cache_result_t r;
    r.kind = kind;
    r.read_data = rd;
    r.memory_address = ma;
    r.memory_data = md;
    r.memory_length = ml;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic bit is_set(bit m[int], int key);
    return m.exists(key) ? m[key] : 1'b0;
  endfunction

  function automatic void predict_access(logic [1:0] op, logic [ADDR_BITS-1:0] addr,
                                         logic [2:0] len, logic [31:0] wd,
                                         logic [31:0] fw);
    int set_no, off, idx, hit, w, base_key;
    logic [TAG_BITS-1:0] tag;
    logic [31:0] mask;
    if (op == OP_FILL) begin
      if (!fill_busy) begin
        push_result(KIND_ERROR, '0, '0, '0, '0, 1'b1);
        return;
      end
      idx = int'(fill_addr[LINE_BITS +: SET_BITS]) * WAYS + fill_way;
      for (int i = 0; i < 4; i++)
        line_store[idx * LINE_SIZE + fill_words * 4 + i] = fw[8*i +: 8];
      fill_words++;
      if (fill_words < LINE_WORDS) return;
      valid_mark[idx] = 1'b1;
      dirty_mark[idx] = 1'b0;
      fill_busy = 1'b0;
      fill_words = 0;
      off = int'(fill_addr[LINE_BITS-1:0]);
      push_result(KIND_RDATA, bytes_at(idx * LINE_SIZE + off, fill_len), '0, '0, '0, 1'b1);
      return;
    end
    off = int'(addr[LINE_BITS-1:0]);
    if ((op != OP_READ && op != OP_WRITE) || fill_busy || len < 1 || len > 4 ||
        off + len > LINE_SIZE) begin
      push_result(KIND_ERROR, '0, '0, '0, '0, 1'b1);
      return;
    end
    set_no = int'(addr[LINE_BITS +: SET_BITS]);
    tag = addr[ADDR_BITS-1 -: TAG_BITS];
    hit = -1;
    for (w = 0; w < WAYS; w++) begin
      idx = set_no * WAYS + w;
      if (is_set(valid_mark, idx) && tags[idx] == tag) begin
        hit = w;
        break;
      end
    end
    if (op == OP_WRITE) begin
      if (hit >= 0) begin
        idx = set_no * WAYS + hit;
        for (int i = 0; i < len; i++) line_store[idx * LINE_SIZE + off + i] = wd[8*i +: 8];
        dirty_mark[idx] = 1'b1;
        push_result(KIND_WRDONE, '0, '0, '0, '0, 1'b1);
      end else begin
        mask = (len >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * len)) - 1);
        push_result(KIND_MEMWR, '0, addr, wd & mask, len, 1'b1);
      end
      return;
    end
    if (hit >= 0) begin
      idx = set_no * WAYS + hit;
      push_result(KIND_RDATA, bytes_at(idx * LINE_SIZE + off, len), '0, '0, '0, 1'b1);
      return;
    end
    // pick the first free way, else let the LFSR choose
    for (w = 0; w < WAYS; w++)
      if (!is_set(valid_mark, set_no * WAYS + w)) break;
    if (w == WAYS) begin
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      w = int'(lfsr[WAY_BITS-1:0]);
    end
    idx = set_no * WAYS + w;
    if (is_set(valid_mark, idx) && is_set(dirty_mark, idx)) begin
      base_key = idx * LINE_SIZE;
      for (int i = 0; i < LINE_WORDS; i++)
        push_result(KIND_MEMWR, '0,
                    {tags[idx], set_no[SET_BITS-1:0], LINE_BITS'(i * 4)},
                    bytes_at(base_key + i * 4, 4), 3'd4, 1'b0);
    end
    valid_mark[idx] = 1'b0;
    dirty_mark[idx] = 1'b0;
    tags[idx] = tag;
    fill_busy = 1'b1;
    fill_addr = addr;
    fill_len = len;
    fill_way = w;
    fill_words = 0;
    push_result(KIND_FILLREQ, '0, {addr[ADDR_BITS-1:LINE_BITS], LINE_BITS'(0)},
                '0, '0, 1'b1);
  endfunction

  initial begin
    failures = 0;
    outstanding = 0;
    lfsr = 16'd1;
    fill_busy = 1'b0;
    fill_words = 0;
    fill_way = 0;
    fill_addr = '0;
    fill_len = '0;
  end

  always @(posedge clk) begin
    cache_result_t got, want;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == REG_RANDOM_SEED)
        lfsr = (cfg_pwdata[15:0] == 16'd0) ? 16'd1 : cfg_pwdata[15:0];
      if (out_mon.valid && out_mon.ready) begin
        got.kind = out_mon.kind;
        got.read_data = out_mon.read_data;
        got.memory_address = out_mon.memory_address;
        got.memory_data = out_mon.memory_data;
        got.memory_length = out_mon.memory_length;
        got.last = out_mon.last;
        if (expected_results.size() == 0) begin
          failures++;
          $display("%0t: unexpected result kind=%0d rd=%h ma=%h md=%h ml=%0d last=%0d",
                   $time, got.kind, got.read_data, got.memory_address,
                   got.memory_data, got.memory_length, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.read_data !== want.read_data ||
              got.memory_address !== want.memory_address ||
              got.memory_data !== want.memory_data ||
              got.memory_length !== want.memory_length || got.last !== want.last) begin
            failures++;
            $display("%0t: expected kind=%0d rd=%h ma=%h md=%h ml=%0d last=%0d", $time,
                     want.kind, want.read_data, want.memory_address,
                     want.memory_data, want.memory_length, want.last);
            $display("%0t: actual   kind=%0d rd=%h ma=%h md=%h ml=%0d last=%0d", $time,
                     got.kind, got.read_data, got.memory_address,
                     got.memory_data, got.memory_length, got.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_access(in_mon.operation, in_mon.address, in_mon.length,
                       in_mon.write_data, in_mon.fill_word);
    end
    outstanding = expected_results.size();
  end

endmodule

/* bench/tb_set_associative_write_back_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_associative_write_back_cache
// Drives directed and random accesses, fill words and seed writes into the
// write-back cache under varying idle patterns; the checker judges results.
// ----------------------------------------------------------------------------
module tb_set_associative_write_back_cache;
  import sawbc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RANDOM_SEED = '0;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int WORDS_PER_LINE = (1 << LINE_BITS) / 4;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;
  int failures, outstanding;
  int cycles;
  int send_idle, recv_idle;
  int fills_owed;
  logic [TAG_BITS-1:0] tag_pool[20];
  logic [SET_BITS-1:0] set_pool[2];

  sawbc_in_if  in_ch();
  sawbc_out_if out_ch();

  set_associative_write_back_cache u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  sawbc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .failures(failures), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("set_associative_write_back_cache: mismatch");
      $finish;
    end
  end

  // count fill requests so the stimulus knows a line is waiting for data
  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.kind == KIND_FILLREQ)
      fills_owed = fills_owed + 1;

  always @(negedge clk)
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  task automatic send(logic [1:0] op, logic [ADDR_BITS-1:0] addr, logic [2:0] len,
                      logic [31:0] wd, logic [31:0] fw);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.address = addr;
    in_ch.length = len;
    in_ch.write_data = wd;
    in_ch.fill_word = fw;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_line(logic [31:0] first_word);
    send(OP_FILL, ADDR_BITS'($urandom), 3'd4, $urandom, first_word);
    for (int i = 1; i < WORDS_PER_LINE; i++)
      send(OP_FILL, ADDR_BITS'($urandom), 3'd4, $urandom, $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_seed(logic [15:0] seed);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = REG_RANDOM_SEED;
    cfg_pwdata = {16'h0, seed};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic random_access();
    logic [1:0] op;
    logic [2:0] len;
    logic [ADDR_BITS-1:0] addr;
    int r, off;
    r = $urandom_range(99);
    op = (r < 55) ? OP_READ : (r < 93) ? OP_WRITE : (r < 97) ? OP_FILL : OP_UNUSED;
    len = ($urandom_range(99) < 5) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    r = $urandom_range(99);
    if (r < 10) begin
      addr = ADDR_BITS'($urandom);
    end else begin
      off = (len >= 1 && len <= 4) ? $urandom_range(64 - len) : $urandom_range(63);
      if (r < 14) off = 63;
      addr = {tag_pool[$urandom_range(19)], set_pool[$urandom_range(1)], LINE_BITS'(off)};
    end
    send(op, addr, len, $urandom, $urandom);
  endtask

  task automatic run_phase(int s_idle, int r_idle, logic [15:0] seed, int items);
    int n;
    bit paused;
    drain();
    send_idle = s_idle;
    recv_idle = r_idle;
    write_seed(seed);
    n = 0;
    paused = 1'b0;
    while (n < items) begin
      if (fills_owed > 0 && $urandom_range(99) < 85) begin
        fills_owed--;
        send_line($urandom);
        n += WORDS_PER_LINE;
      end else begin
        random_access();
        n++;
      end
      // hold off once per phase until every result has come back
      if (!paused && n >= items / 2) begin
        paused = 1'b1;
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (outstanding != 0) @(posedge clk);
      end
    end
    while (fills_owed > 0) begin
      fills_owed--;
      send_line($urandom);
    end
  endtask

  initial begin
    cycles = 0;
    fills_owed = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_READ;
    in_ch.address = '0;
    in_ch.length = 3'd1;
    in_ch.write_data = '0;
    in_ch.fill_word = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    foreach (tag_pool[i]) tag_pool[i] = TAG_BITS'($urandom);
    foreach (set_pool[i]) set_pool[i] = SET_BITS'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: miss and fill, hit, write hit and miss, each error kind
    send(OP_FILL, '0, 3'd4, '0, 32'hFFFF_FFFF);
    send(OP_READ, '0, 3'd1, '0, '0);
    send(OP_WRITE, 27'h10, 3'd4, 32'h1234_5678, '0);
    send_line(32'hFFFF_FFFF);
    fills_owed = 0;
    send(OP_READ, 27'h0, 3'd4, '0, '0);
    send(OP_WRITE, 27'h3C, 3'd4, 32'hFFFF_FFFF, '0);
    send(OP_WRITE, 27'h5, 3'd1, 32'hFFFF_FFA5, '0);
    send(OP_READ, 27'h3C, 3'd4, '0, '0);
    send(OP_READ, 27'h4, 3'd3, '0, '0);
    send(OP_WRITE, 27'h7FF_FFFF, 3'd1, 32'hFFFF_FFFF, '0);
    send(OP_WRITE, 27'h7FF_FFFC, 3'd2, 32'h0, '0);
    send(OP_READ, 27'h3F, 3'd2, '0, '0);
    send(OP_READ, 27'h8, 3'd0, '0, '0);
    send(OP_WRITE, 27'h8, 3'd5, '0, '0);
    send(OP_READ, 27'h8, 3'd7, '0, '0);
    send(OP_UNUSED, 27'h8, 3'd1, '0, '0);
    send(OP_READ, 27'h7FF_FFFF, 3'd1, '0, '0);
    send(OP_READ, 27'h40, 3'd1, '0, '0);
    drain();
    fills_owed = 0;
    send_line(32'h0);

    run_phase(32, 79, 16'd65535, 130);
    run_phase(79, 32, 16'($urandom_range(65535, 1)), 130);
    run_phase(0, 0, 16'd1, 130);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("set_associative_write_back_cache: match");
    end else begin
      $display("set_associative_write_back_cache: mismatch");
    end
    $finish;
  end

endmodule
